// File: hdl/polyline_arc_length_interpolator_unit_macros.svh
// Assertion macros used by the checker file hdl/pali_checker.sv
`ifndef POLYLINE_ARC_LENGTH_INTERPOLATOR_UNIT_MACROS_SVH
`define POLYLINE_ARC_LENGTH_INTERPOLATOR_UNIT_MACROS_SVH

// Same-cycle implication
`define PALI_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define PALI_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/pali_pkg.sv
package pali_pkg;

  localparam int COORD_W   = 32;
  localparam int LEN_W     = 44;
  localparam int FRAC_W    = 17;
  localparam int CNT_OUT_W = 11;
  localparam int ITER_W    = 6;
  localparam int SQ_STEPS   = 3;
  localparam int ROOT_STEPS = 33;
  localparam int MUL_STEPS  = FRAC_W;
  localparam int DIV_STEPS  = 35;
  localparam int MAG_W      = 35;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;
  localparam logic [1:0] CMD_NOP    = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_FEW   = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_APP_RD,
    S_APP_DIFF,
    S_APP_SQ,
    S_APP_RINIT,
    S_APP_ROOT,
    S_APP_WR,
    S_Q_MUL,
    S_Q_SINIT,
    S_Q_SRD,
    S_Q_SCMP,
    S_Q_RD0,
    S_Q_RD1,
    S_Q_LAT,
    S_Q_PREP,
    S_Q_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic       load;
    logic       clear;
    logic       app_rd;
    logic       app_diff;
    logic       sq_step;
    logic       root_init;
    logic       root_step;
    logic       app_wr;
    logic       mul_step;
    logic       srch_init;
    logic       srch_rd;
    logic       srch_cmp;
    logic       seg_rd0;
    logic       seg_rd1;
    logic       seg_lat;
    logic       seg_prep;
    logic       div_step;
    logic       out_load;
    logic       out_query;
    logic [1:0] out_status;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       full;
    logic       few;
    logic       range_err;
    logic       first;
    logic       srch_done;
  } dp_sts_t;

endpackage

// File: hdl/pali_ctrl.sv
module pali_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  pali_pkg::dp_sts_t sts,
  output pali_pkg::dp_cmd_t cmd
);
  import pali_pkg::*;

  state_t            state, state_next;
  logic [ITER_W-1:0] cnt, cnt_next;
  logic [1:0]        st, st_next;
  logic              qok, qok_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      st       <= ST_OK;
      qok      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      st    <= st_next;
      qok   <= qok_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    st_next        = st;
    qok_next       = qok;
    cmd            = '0;
    cmd.out_status = st;
    cmd.out_query  = qok;
    s_tready       = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        st_next  = ST_OK;
        qok_next = 1'b0;
        case (sts.cmd)
          CMD_CLEAR: begin
            cmd.clear  = 1'b1;
            state_next = S_DONE;
          end
          CMD_APPEND: begin
            if (sts.full) begin
              st_next    = ST_FULL;
              state_next = S_DONE;
            end else if (sts.first) begin
              state_next = S_APP_WR;
            end else begin
              state_next = S_APP_RD;
            end
          end
          CMD_QUERY: begin
            if (sts.range_err) begin
              st_next    = ST_RANGE;
              state_next = S_DONE;
            end else if (sts.few) begin
              st_next    = ST_FEW;
              state_next = S_DONE;
            end else begin
              cnt_next   = '0;
              state_next = S_Q_MUL;
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_APP_RD: begin
        cmd.app_rd = 1'b1;
        state_next = S_APP_DIFF;
      end
      S_APP_DIFF: begin
        cmd.app_diff = 1'b1;
        cnt_next     = '0;
        state_next   = S_APP_SQ;
      end
      S_APP_SQ: begin
        cmd.sq_step = 1'b1;
        if (cnt == ITER_W'(SQ_STEPS - 1)) begin
          state_next = S_APP_RINIT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_APP_RINIT: begin
        cmd.root_init = 1'b1;
        cnt_next      = '0;
        state_next    = S_APP_ROOT;
      end
      S_APP_ROOT: begin
        cmd.root_step = 1'b1;
        if (cnt == ITER_W'(ROOT_STEPS - 1)) begin
          state_next = S_APP_WR;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_APP_WR: begin
        cmd.app_wr = 1'b1;
        state_next = S_DONE;
      end
      S_Q_MUL: begin
        cmd.mul_step = 1'b1;
        if (cnt == ITER_W'(MUL_STEPS - 1)) begin
          state_next = S_Q_SINIT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_Q_SINIT: begin
        cmd.srch_init = 1'b1;
        state_next    = S_Q_SRD;
      end
      S_Q_SRD: begin
        if (sts.srch_done) begin
          state_next = S_Q_RD0;
        end else begin
          cmd.srch_rd = 1'b1;
          state_next  = S_Q_SCMP;
        end
      end
      S_Q_SCMP: begin
        cmd.srch_cmp = 1'b1;
        state_next   = S_Q_SRD;
      end
      S_Q_RD0: begin
        cmd.seg_rd0 = 1'b1;
        state_next  = S_Q_RD1;
      end
      S_Q_RD1: begin
        cmd.seg_rd1 = 1'b1;
        state_next  = S_Q_LAT;
      end
      S_Q_LAT: begin
        cmd.seg_lat = 1'b1;
        state_next  = S_Q_PREP;
      end
      S_Q_PREP: begin
        cmd.seg_prep = 1'b1;
        cnt_next     = '0;
        state_next   = S_Q_DIV;
      end
      S_Q_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == ITER_W'(DIV_STEPS - 1)) begin
          qok_next   = 1'b1;
          state_next = S_DONE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: hdl/pali_dp.sv
module pali_dp #(
  parameter int MAX_POINTS    = 1024,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pali_pkg::dp_cmd_t                   cmd,
  output pali_pkg::dp_sts_t                   sts,
  input  logic [1:0]                          in_command,
  input  logic [pali_pkg::COORD_W-1:0]        in_x,
  input  logic [pali_pkg::COORD_W-1:0]        in_y,
  input  logic [pali_pkg::COORD_W-1:0]        in_z,
  input  logic [pali_pkg::FRAC_W-1:0]         in_frac,
  output logic [pali_pkg::COORD_W-1:0]        res_x,
  output logic [pali_pkg::COORD_W-1:0]        res_y,
  output logic [pali_pkg::COORD_W-1:0]        res_z,
  output logic [1:0]                          res_status,
  output logic [pali_pkg::CNT_OUT_W-1:0]      res_count
);
  import pali_pkg::*;

  localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW    = $clog2(MAX_POINTS + 1);
  localparam int ACC_W = FRAC_W + LEN_W;
  localparam int PT_W  = 3 * COORD_W;
  localparam int CMPW  = FRAC_W + FRACTION_BITS + 1;

  logic [CW-1:0]      count;
  logic [LEN_W-1:0]   total;
  logic [1:0]         cmd_r;
  logic [PT_W-1:0]    pin;
  logic [FRAC_W-1:0]  frac;

  logic [PT_W-1:0]    mem_pt [MAX_POINTS];
  logic [LEN_W-1:0]   mem_cl [MAX_POINTS];
  logic [PT_W-1:0]    rd_pt;
  logic [LEN_W-1:0]   rd_cl;
  logic [AW-1:0]      rd_addr;
  logic               rd_en;
  logic               wr_en;

  logic [COORD_W-1:0] dm [3];
  logic [65:0]        sq_sum;
  logic [65:0]        rad;
  logic [34:0]        rem;
  logic [32:0]        root;
  logic [36:0]        r2;
  logic [36:0]        tt;
  logic [LEN_W:0]     len_sum;
  logic [LEN_W-1:0]   len_new;

  logic [ACC_W-1:0]   acc;
  logic [FRAC_W-1:0]  fsh;
  logic [LEN_W-1:0]   tgt;
  logic [AW-1:0]      lo, hi, mid;
  logic [AW:0]        lohi;

  logic [LEN_W-1:0]   c0, c1, seg, num;
  logic [PT_W-1:0]    p0, p1;
  logic               start_pt;
  logic [MAG_W-1:0]   mag [3];
  logic               neg [3];
  logic [LEN_W-1:0]   rr [3];
  logic [MAG_W-1:0]   rq [3];
  logic [COORD_W-1:0] lerp [3];

  assign sts.cmd       = cmd_r;
  assign sts.full      = (count >= CW'(MAX_POINTS));
  assign sts.few       = (count < CW'(2));
  assign sts.first     = (count == '0);
  assign sts.range_err = (CMPW'(frac) > (CMPW'(1) << FRACTION_BITS));
  assign sts.srch_done = (lo >= hi);

  assign lohi = (AW + 1)'(lo) + (AW + 1)'(hi);
  assign mid  = lohi[AW:1];

  always_comb begin
    rd_en   = 1'b1;
    rd_addr = lo;
    if (cmd.app_rd) begin
      rd_addr = AW'(count - CW'(1));
    end else if (cmd.srch_rd) begin
      rd_addr = mid;
    end else if (cmd.seg_rd0) begin
      rd_addr = lo - AW'(1);
    end else if (cmd.seg_rd1) begin
      rd_addr = lo;
    end else begin
      rd_en = 1'b0;
    end
  end

  assign wr_en   = cmd.app_wr;
  assign r2      = {rem, rad[65:64]};
  assign tt      = {2'b00, root, 2'b01};
  assign len_sum = {1'b0, total} + (LEN_W + 1)'(root);
  assign len_new = sts.first ? '0 : (len_sum[LEN_W] ? '1 : len_sum[LEN_W-1:0]);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_pt[count[AW-1:0]] <= pin;
      mem_cl[count[AW-1:0]] <= len_new;
    end
    if (rd_en) begin
      rd_pt <= mem_pt[rd_addr];
      rd_cl <= mem_cl[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      total <= '0;
    end else if (cmd.clear) begin
      count <= '0;
      total <= '0;
    end else if (cmd.app_wr) begin
      count <= count + CW'(1);
      total <= len_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_command;
      pin   <= {in_z, in_y, in_x};
      frac  <= in_frac;
      fsh   <= in_frac;
      acc   <= '0;
    end else if (cmd.mul_step) begin
      acc <= (acc << 1) + (fsh[FRAC_W-1] ? ACC_W'(total) : '0);
      fsh <= fsh << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.app_diff) begin
      for (int a = 0; a < 3; a++) begin
        logic [COORD_W:0] d;
        d = {pin[a*COORD_W+COORD_W-1], pin[a*COORD_W +: COORD_W]}
          - {rd_pt[a*COORD_W+COORD_W-1], rd_pt[a*COORD_W +: COORD_W]};
        dm[a] <= d[COORD_W] ? COORD_W'(-d) : d[COORD_W-1:0];
      end
      sq_sum <= '0;
    end else if (cmd.sq_step) begin
      sq_sum <= sq_sum + 66'(dm[0] * dm[0]);
      dm[0]  <= dm[1];
      dm[1]  <= dm[2];
      dm[2]  <= dm[0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.root_init) begin
      rad  <= sq_sum;
      rem  <= '0;
      root <= '0;
    end else if (cmd.root_step) begin
      rad <= rad << 2;
      if (r2 >= tt) begin
        rem  <= 35'(r2 - tt);
        root <= {root[31:0], 1'b1};
      end else begin
        rem  <= r2[34:0];
        root <= {root[31:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.srch_init) begin
      tgt <= LEN_W'(acc >> FRACTION_BITS);
      lo  <= AW'(1);
      hi  <= AW'(count - CW'(1));
    end else if (cmd.srch_cmp) begin
      if (rd_cl >= tgt) begin
        hi <= mid;
      end else begin
        lo <= mid + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.seg_rd1) begin
      c0 <= rd_cl;
      p0 <= rd_pt;
    end
    if (cmd.seg_lat) begin
      c1 <= rd_cl;
      p1 <= rd_pt;
    end
    if (cmd.seg_prep) begin
      seg      <= c1 - c0;
      start_pt <= (c1 == c0) || (tgt < c0);
      num      <= (tgt > c1) ? (c1 - c0) : (tgt - c0);
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic [COORD_W:0]   d;
    logic [COORD_W-1:0] dmag;
    logic [LEN_W:0]     s1, s2, s3, s4;
    logic               inc1, inc2;

    assign d    = {p1[a*COORD_W+COORD_W-1], p1[a*COORD_W +: COORD_W]}
                - {p0[a*COORD_W+COORD_W-1], p0[a*COORD_W +: COORD_W]};
    assign dmag = d[COORD_W] ? COORD_W'(-d) : d[COORD_W-1:0];
    assign s1   = {rr[a], 1'b0};
    assign inc1 = (s1 >= {1'b0, seg});
    assign s2   = inc1 ? (s1 - {1'b0, seg}) : s1;
    assign s3   = mag[a][MAG_W-1] ? (s2 + {1'b0, num}) : s2;
    assign inc2 = mag[a][MAG_W-1] && (s3 >= {1'b0, seg});
    assign s4   = inc2 ? (s3 - {1'b0, seg}) : s3;
    assign lerp[a] = start_pt ? p0[a*COORD_W +: COORD_W]
                   : (neg[a] ? p0[a*COORD_W +: COORD_W] - rq[a][COORD_W-1:0]
                             : p0[a*COORD_W +: COORD_W] + rq[a][COORD_W-1:0]);

    always_ff @(posedge clk) begin
      if (cmd.seg_prep) begin
        neg[a] <= d[COORD_W];
        mag[a] <= MAG_W'(dmag);
        rr[a]  <= '0;
        rq[a]  <= '0;
      end else if (cmd.div_step) begin
        mag[a] <= mag[a] << 1;
        rr[a]  <= s4[LEN_W-1:0];
        rq[a]  <= (rq[a] << 1) + MAG_W'(inc1) + MAG_W'(inc2);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_x      <= cmd.out_query ? lerp[0] : '0;
      res_y      <= cmd.out_query ? lerp[1] : '0;
      res_z      <= cmd.out_query ? lerp[2] : '0;
      res_status <= cmd.out_status;
      res_count  <= CNT_OUT_W'(count);
    end
  end

endmodule

// File: hdl/polyline_arc_length_interpolator_unit.sv
// Polyline arc-length interpolator.
// Input stream (s_*): one request per accepted beat; s_tuser carries the command
// (clear, append point, query by fraction, no-op), s_tdata the point and fraction.
// Output stream (m_*): exactly one result per request, in request order; m_tuser
// carries the status, m_tdata the coordinates and the point count after the request.
// Requests are handled one at a time; s_tready is high only while the unit is idle,
// and it stays high while a finished result waits in the output register.
// Clear, no-op and rejected requests go from decode straight to the result. An
// append runs a 33-step square-root loop after three passes of one 32x32
// multiplier (the first point skips both); a query runs 17 shift-add steps for
// the target length, a binary search on the single read port of the length
// memory, and a 35-step serial multiply-divide run for the three axes in parallel.
// Reset empties the polyline (count and total length go to zero) and drops any
// pending result. Point and length memories need no clearing pass.
// When m_tready is low the result holds in the output register; the unit then
// accepts one more request and stalls before delivering it.
module polyline_arc_length_interpolator_unit #(
  parameter int MAX_POINTS    = 1024,
  parameter int FRACTION_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [119:0] s_tdata,   // point_x, point_y, point_z, position_fraction, zero pad
  input  logic [1:0]   s_tuser,   // command
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [111:0] m_tdata,   // result_x, result_y, result_z, point_count, zero pad
  output logic [1:0]   m_tuser    // status
);
  import pali_pkg::*;

  dp_cmd_t              cmd;
  dp_sts_t              sts;
  logic [COORD_W-1:0]   res_x, res_y, res_z;
  logic [1:0]           res_status;
  logic [CNT_OUT_W-1:0] res_count;

  pali_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pali_dp #(
    .MAX_POINTS    (MAX_POINTS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_command (s_tuser),
    .in_x       (s_tdata[31:0]),
    .in_y       (s_tdata[63:32]),
    .in_z       (s_tdata[95:64]),
    .in_frac    (s_tdata[112:96]),
    .res_x      (res_x),
    .res_y      (res_y),
    .res_z      (res_z),
    .res_status (res_status),
    .res_count  (res_count)
  );

  assign m_tdata = {5'b0, res_count, res_z, res_y, res_x};
  assign m_tuser = res_status;

endmodule

// File: hdl/pali_checker.sv
`include "polyline_arc_length_interpolator_unit_macros.svh"

module pali_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [111:0] m_tdata,
  input logic [1:0]   m_tuser
);
  import pali_pkg::*;

  `PALI_ASSERT_NXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid, "result dropped")
  `PALI_ASSERT_NXT(a_out_stable, clk, rst, m_tvalid && !m_tready, $stable(m_tdata), "result changed")
  `PALI_ASSERT_NXT(a_busy, clk, rst, s_tvalid && s_tready, !s_tready, "request taken while busy")
  `PALI_ASSERT_IMP(a_err_zero, clk, rst, m_tvalid && m_tuser != ST_OK, m_tdata[95:0] == '0, "coords")

endmodule

bind polyline_arc_length_interpolator_unit pali_checker u_pali_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// File: tb/polyline_checker.sv
`timescale 1ns / 1ps
module polyline_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [119:0] s_tdata,
  input  logic [1:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [111:0] m_tdata,
  input  logic [1:0]   m_tuser,
  output int           errors,
  output int           pending
);
  import pali_pkg::*;

  localparam int NPTS = 1024;
  localparam logic [43:0] LEN_SAT = {44{1'b1}};

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [1:0]  status;
    logic [10:0] npts;
  } point_result_t;

  logic [31:0] px [NPTS];
  logic [31:0] py [NPTS];
  logic [31:0] pz [NPTS];
  logic [43:0] cum_len [NPTS];
  logic [43:0] arc_total;
  int unsigned npoints;
  point_result_t expected_results[$];

  function automatic logic [63:0] abs_gap(logic [31:0] a, logic [31:0] b);
    longint d;
    d = longint'($signed(a)) - longint'($signed(b));
    return d < 0 ? -d : d;
  endfunction

  function automatic logic [63:0] floor_root(logic [65:0] v);
    logic [67:0] rem;
    logic [67:0] trial;
    logic [63:0] root;
    rem = 0;
    root = 0;
    for (int k = 32; k >= 0; k--) begin
      rem = (rem << 2) | v[2*k +: 2];
      trial = {root, 2'b01};
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic logic [63:0] scale_div(logic [63:0] a, logic [63:0] b, logic [63:0] c);
    logic [63:0] q;
    logic [63:0] r;
    q = 0;
    r = 0;
    for (int k = 34; k >= 0; k--) begin
      q = q << 1;
      r = r << 1;
      if (r >= c) begin
        r -= c;
        q++;
      end
      if (a[k]) begin
        r += b;
        if (r >= c) begin
          r -= c;
          q++;
        end
      end
    end
    return q;
  endfunction

  function automatic logic [31:0] blend(logic [31:0] p0, logic [31:0] p1,
                                       logic [63:0] num, logic [63:0] seg);
    longint d;
    longint q;
    d = longint'($signed(p1)) - longint'($signed(p0));
    q = scale_div(d < 0 ? -d : d, num, seg);
    return d < 0 ? 32'(longint'($signed(p0)) - q) : 32'(longint'($signed(p0)) + q);
  endfunction

  function automatic point_result_t predict_point(logic [1:0] cmd, logic [119:0] d);
    point_result_t r;
    logic [63:0] dx, dy, dz, tgt, c0, seg, num;
    logic [65:0] sq;
    logic [63:0] sum;
    logic [16:0] frac;
    int unsigned n;
    r = '0;
    case (cmd)
      CMD_CLEAR: begin
        npoints = 0;
        arc_total = 0;
      end
      CMD_APPEND: begin
        if (npoints >= NPTS) begin
          r.status = ST_FULL;
        end else begin
          if (npoints == 0) begin
            arc_total = 0;
            cum_len[0] = 0;
          end else begin
            dx = abs_gap(d[31:0], px[npoints-1]);
            dy = abs_gap(d[63:32], py[npoints-1]);
            dz = abs_gap(d[95:64], pz[npoints-1]);
            sq = 66'(dx * dx) + 66'(dy * dy) + 66'(dz * dz);
            sum = 64'(arc_total) + floor_root(sq);
            arc_total = sum > 64'(LEN_SAT) ? LEN_SAT : sum[43:0];
            cum_len[npoints] = arc_total;
          end
          px[npoints] = d[31:0];
          py[npoints] = d[63:32];
          pz[npoints] = d[95:64];
          npoints++;
        end
      end
      CMD_QUERY: begin
        frac = d[112:96];
        if (frac > 17'd65536) begin
          r.status = ST_RANGE;
        end else if (npoints < 2) begin
          r.status = ST_FEW;
        end else begin
          tgt = (64'(frac) * 64'(arc_total)) >> 16;
          for (n = 1; n < npoints - 1; n++)
            if (cum_len[n-1] <= tgt && cum_len[n] >= tgt) break;
          c0 = cum_len[n-1];
          seg = cum_len[n] - c0;
          if (seg == 0 || tgt < c0) begin
            r.x = px[n-1];
            r.y = py[n-1];
            r.z = pz[n-1];
          end else begin
            num = tgt - c0;
            if (num > seg) num = seg;
            r.x = blend(px[n-1], px[n], num, seg);
            r.y = blend(py[n-1], py[n], num, seg);
            r.z = blend(pz[n-1], pz[n], num, seg);
          end
        end
      end
      default: ;
    endcase
    r.npts = 11'(npoints);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  assign pending = expected_results.size();

  initial begin
    errors = 0;
    npoints = 0;
    arc_total = 0;
  end

  always @(posedge clk) begin
    point_result_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 32'(m_tuser), 0);
        end else begin
          want = expected_results.pop_front();
          if (m_tdata[31:0] !== want.x) report_mismatch("result_x", m_tdata[31:0], want.x);
          if (m_tdata[63:32] !== want.y) report_mismatch("result_y", m_tdata[63:32], want.y);
          if (m_tdata[95:64] !== want.z) report_mismatch("result_z", m_tdata[95:64], want.z);
          if (m_tdata[106:96] !== want.npts)
            report_mismatch("point_count", 32'(m_tdata[106:96]), 32'(want.npts));
          if (m_tuser !== want.status)
            report_mismatch("status", 32'(m_tuser), 32'(want.status));
        end
      end
      if (s_tvalid && s_tready)
        expected_results = {expected_results, predict_point(s_tuser, s_tdata)};
    end
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import pali_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [119:0] s_tdata = '0;
  logic [1:0]   s_tuser = CMD_NOP;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [111:0] m_tdata;
  logic [1:0]   m_tuser;
  int           errors;
  int           pending;
  int           send_idle_pct = 6;
  int           recv_idle_pct = 51;
  bit           hold_off = 0;
  int           quiet_cycles = 0;
  int           held_points = 0;

  always #5 clk = ~clk;

  polyline_arc_length_interpolator_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  polyline_checker checker_i (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .errors(errors), .pending(pending)
  );

  always @(posedge clk) begin
    if (rst) m_tready <= 0;
    else m_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send(logic [1:0] cmd, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                      logic [16:0] frac);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= cmd;
    s_tdata <= {7'b0, frac, z, y, x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (cmd == CMD_CLEAR) held_points = 0;
    else if (cmd == CMD_APPEND && held_points < 1024) held_points++;
  endtask

  task automatic drain_requests();
    s_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] near_coord(logic [31:0] base);
    return base + 32'($signed($urandom_range(4000000)) - 2000000);
  endfunction

  function automatic logic [16:0] pick_fraction();
    case ($urandom_range(9))
      0: return 17'($urandom_range(131071));
      1: return 17'd65536;
      2: return 17'd0;
      default: return 17'($urandom_range(65536));
    endcase
  endfunction

  task automatic random_phase(int items);
    logic [31:0] x, y, z;
    x = $urandom;
    y = $urandom;
    z = $urandom;
    for (int i = 0; i < items; i++) begin
      case ($urandom_range(39))
        0: send(CMD_CLEAR, $urandom, $urandom, $urandom, 17'($urandom));
        1: send(CMD_NOP, $urandom, $urandom, $urandom, 17'($urandom));
        2, 3: begin
          x = $urandom; y = $urandom; z = $urandom;
          send(CMD_APPEND, x, y, z, 17'($urandom));
        end
        4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15, 16, 17, 18, 19, 20, 21, 22, 23: begin
          if ($urandom_range(5) == 0) begin
            x = x; y = y; z = z;
          end else begin
            x = near_coord(x); y = near_coord(y); z = near_coord(z);
          end
          send(CMD_APPEND, x, y, z, 17'($urandom));
        end
        default: send(CMD_QUERY, $urandom, $urandom, $urandom, pick_fraction());
      endcase
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send(CMD_QUERY, 0, 0, 0, 17'd100);
    send(CMD_QUERY, 0, 0, 0, 17'd131071);
    send(CMD_QUERY, 0, 0, 0, 17'd65537);
    send(CMD_APPEND, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
    send(CMD_QUERY, 0, 0, 0, 17'd65536);
    send(CMD_APPEND, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    send(CMD_APPEND, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    send(CMD_APPEND, 32'h0, 32'hFFFF_FFFF, 32'h0001_0000, 0);
    send(CMD_QUERY, 0, 0, 0, 17'd0);
    send(CMD_QUERY, 0, 0, 0, 17'd32768);
    send(CMD_QUERY, 0, 0, 0, 17'd65535);
    send(CMD_QUERY, 0, 0, 0, 17'd65536);
    send(CMD_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'd12345);
    send(CMD_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'h1FFFF);
    send(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'h1FFFF);
    send(CMD_QUERY, 0, 0, 0, 17'd1000);
    send(CMD_APPEND, 32'h0001_0000, 0, 0, 0);
    send(CMD_APPEND, 32'h0001_0000, 0, 0, 0);
    send(CMD_APPEND, 32'h0003_0000, 32'h0004_0000, 0, 0);
    send(CMD_QUERY, 0, 0, 0, 17'd16384);
    send(CMD_QUERY, 0, 0, 0, 17'd50000);
    drain_requests();

    while (held_points < 1024)
      send(CMD_APPEND, $urandom_range(65535) * held_points, 32'h0, $urandom, 0);
    send(CMD_APPEND, 1, 2, 3, 0);
    send(CMD_QUERY, 0, 0, 0, 17'd40000);
    send(CMD_QUERY, 0, 0, 0, 17'd65536);
    send(CMD_CLEAR, 0, 0, 0, 0);

    random_phase(300);
    drain_requests();
    send_idle_pct = 51;
    recv_idle_pct = 6;
    random_phase(200);

    hold_off = 1;
    fork
      begin
        for (int i = 0; i < 6; i++) send(CMD_NOP, $urandom, $urandom, $urandom, 0);
      end
      begin
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
    join
    random_phase(150);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(150);
    drain_requests();

    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
